@@ rtl/core/dewk_pkg.sv @@
package dewk_pkg;

    localparam int MAX_DEPTH_DEF = 8;

    // Result queue between the walker and the output port.
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_LVL_W = $clog2(RESQ_DEPTH + 1);

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] ERR_TOO_SMALL    = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_ENCAPSULATED = 3'd2;
    localparam logic [2:0] ERR_MALFORMED    = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd4;
    localparam logic [2:0] ERR_NO_PIXEL     = 3'd5;

    localparam logic [15:0] TAG_DELIM_GROUP = 16'hFFFE;
    localparam logic [15:0] TAG_ITEM_DELIM  = 16'hE00D;
    localparam logic [15:0] TAG_SEQ_DELIM   = 16'hE0DD;
    localparam logic [15:0] TAG_ITEM_START  = 16'hE000;
    localparam logic [15:0] PIXEL_GROUP     = 16'h7FE0;
    localparam logic [15:0] PIXEL_ELEMENT   = 16'h0010;
    localparam logic [31:0] UNDEF_LEN       = 32'hFFFF_FFFF;
    localparam logic [31:0] MAGIC_WORD      = 32'h4D43_4944;
    localparam logic [7:0]  PREAMBLE_LEN    = 8'd128;
    localparam logic [7:0]  MAGIC_LAST      = 8'd131;

    // Two-character VR codes, first character in the low byte.
    localparam logic [15:0] VR_OB = 16'h424F;
    localparam logic [15:0] VR_OW = 16'h574F;
    localparam logic [15:0] VR_OF = 16'h464F;
    localparam logic [15:0] VR_SQ = 16'h5153;
    localparam logic [15:0] VR_UT = 16'h5455;
    localparam logic [15:0] VR_UN = 16'h4E55;

    localparam logic NK_SEQ  = 1'b0;
    localparam logic NK_ITEM = 1'b1;

    typedef enum logic [4:0] {
        PH_PRE  = 5'b00001,
        PH_HDR  = 5'b00010,
        PH_VAL  = 5'b00100,
        PH_SKIP = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] group_number;
        logic [15:0] element_number;
        logic [7:0]  value_byte;
        logic [31:0] value_index;
        logic        value_end;
        logic [2:0]  error_code;
        logic        run_last;
    } t_result;

    // Results caused by one input word; v1 is only ever set together with v0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_step;

    typedef struct packed {
        logic phase_pre;
        logic top_level;
    } t_walk_status;

    function automatic t_result mk_res(input logic [1:0] kind, input logic [15:0] g,
                                       input logic [15:0] e, input logic [7:0] vb,
                                       input logic [31:0] vi, input logic ve,
                                       input logic [2:0] ec);
        t_result r;
        r.kind           = kind;
        r.group_number   = g;
        r.element_number = e;
        r.value_byte     = vb;
        r.value_index    = vi;
        r.value_end      = ve;
        r.error_code     = ec;
        r.run_last       = 1'b0;
        return r;
    endfunction

    function automatic t_step step_add(input t_step s, input t_result r);
        t_step o;
        o = s;
        if (!s.v0) begin
            o.v0 = 1'b1;
            o.r0 = r;
        end else begin
            o.v1 = 1'b1;
            o.r1 = r;
        end
        return o;
    endfunction

    function automatic t_step step_close(input t_step s);
        t_step o;
        o = s;
        if (s.v1) begin
            o.r1.run_last = 1'b1;
        end else if (s.v0) begin
            o.r0.run_last = 1'b1;
        end
        return o;
    endfunction

    function automatic logic is_long_vr(input logic [15:0] v);
        return (v == VR_OB) || (v == VR_OW) || (v == VR_OF) ||
               (v == VR_SQ) || (v == VR_UT) || (v == VR_UN);
    endfunction

endpackage

@@ rtl/core/dewk_walker.sv @@
module dewk_walker #(
    parameter int MAX_DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_stream_end,
    output dewk_pkg::t_step        o_step,
    output dewk_pkg::t_walk_status o_status
);
    import dewk_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    t_phase              r_phase, n_phase;
    logic [7:0]          r_hcnt, n_hcnt;
    logic [15:0]         r_tag_group, n_tag_group;
    logic [15:0]         r_tag_element, n_tag_element;
    logic [15:0]         r_vr, n_vr;
    logic [31:0]         r_len, n_len;
    logic [31:0]         r_rem, n_rem;
    logic [31:0]         r_pos, n_pos;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic                r_nest [MAX_DEPTH];

    logic [DEPTH_W-1:0]  depth_m1;
    logic [IDX_W-1:0]    top_idx;
    logic                in_top, in_item, in_seq;
    logic                push_en, push_kind;

    assign depth_m1 = r_depth - DEPTH_W'(1);
    assign top_idx  = depth_m1[IDX_W-1:0];
    assign in_top   = (r_depth == '0);
    assign in_item  = !in_top && (r_nest[top_idx] == NK_ITEM);
    assign in_seq   = !in_top && !in_item;

    always_comb begin
        logic [7:0]  idx;
        logic [15:0] tg, te, vr;
        logic [31:0] lf, act_len, rem_d;
        logic        lng, is_pix, elem_done;
        logic        do_start, do_push, push_item, do_pop, do_skip, do_fail;
        logic [2:0]  fail_code;
        t_step       step;

        idx       = r_hcnt;
        tg        = r_tag_group;
        te        = r_tag_element;
        vr        = r_vr;
        lf        = r_len;
        act_len   = '0;
        rem_d     = '0;
        lng       = 1'b0;
        is_pix    = 1'b0;
        elem_done = 1'b0;
        do_start  = 1'b0;
        do_push   = 1'b0;
        push_item = 1'b0;
        do_pop    = 1'b0;
        do_skip   = 1'b0;
        do_fail   = 1'b0;
        fail_code = ERR_TOO_SMALL;
        step      = '0;

        n_phase       = r_phase;
        n_hcnt        = r_hcnt;
        n_tag_group   = r_tag_group;
        n_tag_element = r_tag_element;
        n_vr          = r_vr;
        n_len         = r_len;
        n_rem         = r_rem;
        n_pos         = r_pos;
        n_depth       = r_depth;
        push_en       = 1'b0;
        push_kind     = NK_SEQ;

        if (i_valid) begin
            case (r_phase)
                PH_PRE: begin
                    n_hcnt = r_hcnt + 8'd1;
                    case (idx)
                        8'd128:  lf[7:0]   = lf[7:0]   | i_data_byte;
                        8'd129:  lf[15:8]  = lf[15:8]  | i_data_byte;
                        8'd130:  lf[23:16] = lf[23:16] | i_data_byte;
                        8'd131:  lf[31:24] = lf[31:24] | i_data_byte;
                        default: ;
                    endcase
                    n_len = lf;
                    if (idx >= MAGIC_LAST) begin
                        if (lf != MAGIC_WORD) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_BAD_MAGIC;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                end
                PH_HDR: begin
                    n_hcnt = r_hcnt + 8'd1;
                    case (idx)
                        8'd0:    tg[7:0]  = tg[7:0]  | i_data_byte;
                        8'd1:    tg[15:8] = tg[15:8] | i_data_byte;
                        8'd2:    te[7:0]  = te[7:0]  | i_data_byte;
                        8'd3:    te[15:8] = te[15:8] | i_data_byte;
                        default: ;
                    endcase
                    if (in_seq) begin
                        // Inside a sequence only item and delimiter headers may appear;
                        // they carry no VR, the length follows the tag directly.
                        case (idx)
                            8'd4:    lf[7:0]   = lf[7:0]   | i_data_byte;
                            8'd5:    lf[15:8]  = lf[15:8]  | i_data_byte;
                            8'd6:    lf[23:16] = lf[23:16] | i_data_byte;
                            8'd7:    lf[31:24] = lf[31:24] | i_data_byte;
                            default: ;
                        endcase
                        if (idx == 8'd3 && !(tg == TAG_DELIM_GROUP &&
                            (te == TAG_SEQ_DELIM || te == TAG_ITEM_START))) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_MALFORMED;
                        end else if (idx == 8'd7) begin
                            if (te == TAG_SEQ_DELIM) begin
                                do_pop = 1'b1;
                            end else if (lf == UNDEF_LEN) begin
                                do_push   = 1'b1;
                                push_item = 1'b1;
                            end else begin
                                do_skip = 1'b1;
                                act_len = lf;
                            end
                        end
                    end else begin
                        case (idx)
                            8'd4:    vr[7:0]  = vr[7:0]  | i_data_byte;
                            8'd5:    vr[15:8] = vr[15:8] | i_data_byte;
                            default: ;
                        endcase
                        lng = is_long_vr(vr);
                        if (!lng) begin
                            case (idx)
                                8'd6:    lf[7:0]  = lf[7:0]  | i_data_byte;
                                8'd7:    lf[15:8] = lf[15:8] | i_data_byte;
                                default: ;
                            endcase
                        end else begin
                            case (idx)
                                8'd8:    lf[7:0]   = lf[7:0]   | i_data_byte;
                                8'd9:    lf[15:8]  = lf[15:8]  | i_data_byte;
                                8'd10:   lf[23:16] = lf[23:16] | i_data_byte;
                                8'd11:   lf[31:24] = lf[31:24] | i_data_byte;
                                default: ;
                            endcase
                        end
                        is_pix = (tg == PIXEL_GROUP) && (te == PIXEL_ELEMENT);
                        if (idx == 8'd7) begin
                            if (in_item && tg == TAG_DELIM_GROUP && te == TAG_ITEM_DELIM) begin
                                do_pop = 1'b1;
                            end else if (!lng) begin
                                elem_done = 1'b1;
                            end
                        end else if (idx == 8'd11) begin
                            elem_done = 1'b1;
                        end
                        if (elem_done) begin
                            if (in_item) begin
                                if (lf == UNDEF_LEN) begin
                                    do_push = 1'b1;
                                end else begin
                                    do_skip = 1'b1;
                                    act_len = lf;
                                end
                            end else if (lf == UNDEF_LEN) begin
                                if (is_pix) begin
                                    do_fail   = 1'b1;
                                    fail_code = ERR_ENCAPSULATED;
                                end else begin
                                    do_push = 1'b1;
                                end
                            end else if (lf == '0) begin
                                step = step_add(step, mk_res(KIND_EMPTY, tg, te, 8'd0, 32'd0,
                                                             1'b0, ERR_TOO_SMALL));
                                if (is_pix) begin
                                    step    = step_add(step, mk_res(KIND_DONE, 16'd0, 16'd0,
                                                                    8'd0, 32'd0, 1'b0,
                                                                    ERR_TOO_SMALL));
                                    n_phase = PH_DONE;
                                end else begin
                                    do_start = 1'b1;
                                end
                            end else begin
                                n_phase = PH_VAL;
                                n_rem   = lf;
                                n_pos   = '0;
                            end
                        end
                    end
                    n_tag_group   = tg;
                    n_tag_element = te;
                    n_vr          = vr;
                    n_len         = lf;
                end
                PH_VAL: begin
                    step  = step_add(step, mk_res(KIND_VALUE, r_tag_group, r_tag_element,
                                                  i_data_byte, r_pos, (r_rem == 32'd1),
                                                  ERR_TOO_SMALL));
                    n_pos = r_pos + 32'd1;
                    n_rem = r_rem - 32'd1;
                    if (r_rem == 32'd1) begin
                        if (r_tag_group == PIXEL_GROUP && r_tag_element == PIXEL_ELEMENT) begin
                            step    = step_add(step, mk_res(KIND_DONE, 16'd0, 16'd0, 8'd0,
                                                            32'd0, 1'b0, ERR_TOO_SMALL));
                            n_phase = PH_DONE;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                end
                PH_SKIP: begin
                    rem_d = (r_rem != '0) ? (r_rem - 32'd1) : '0;
                    n_rem = rem_d;
                    if (rem_d == '0) begin
                        do_start = 1'b1;
                    end
                end
                default: ;
            endcase

            if (do_push) begin
                if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_MALFORMED;
                end else begin
                    push_en   = 1'b1;
                    push_kind = push_item ? NK_ITEM : NK_SEQ;
                    n_depth   = r_depth + DEPTH_W'(1);
                    do_start  = 1'b1;
                end
            end
            if (do_pop) begin
                if (r_depth != '0) begin
                    n_depth = depth_m1;
                end
                do_start = 1'b1;
            end
            if (do_skip) begin
                if (act_len == '0) begin
                    do_start = 1'b1;
                end else begin
                    n_phase = PH_SKIP;
                    n_rem   = act_len;
                end
            end
            if (do_start) begin
                n_phase       = PH_HDR;
                n_hcnt        = '0;
                n_tag_group   = '0;
                n_tag_element = '0;
                n_vr          = '0;
                n_len         = '0;
            end
            if (do_fail) begin
                step    = step_add(step, mk_res(KIND_ERROR, 16'd0, 16'd0, 8'd0, 32'd0,
                                                1'b0, fail_code));
                n_phase = PH_DONE;
            end

            // The last word of a file reports how the walk ended and re-arms the walker.
            if (i_stream_end) begin
                if (n_phase == PH_PRE) begin
                    step = step_add(step, mk_res(KIND_ERROR, 16'd0, 16'd0, 8'd0, 32'd0,
                                                 1'b0, ERR_TOO_SMALL));
                end else if (n_phase == PH_VAL) begin
                    step = step_add(step, mk_res(KIND_ERROR, 16'd0, 16'd0, 8'd0, 32'd0,
                                                 1'b0, ERR_TRUNCATED));
                end else if (n_phase != PH_DONE) begin
                    step = step_add(step, mk_res(KIND_ERROR, 16'd0, 16'd0, 8'd0, 32'd0,
                                                 1'b0, (n_depth != '0) ? ERR_MALFORMED
                                                                       : ERR_NO_PIXEL));
                end
                n_phase       = PH_PRE;
                n_hcnt        = '0;
                n_tag_group   = '0;
                n_tag_element = '0;
                n_vr          = '0;
                n_len         = '0;
                n_rem         = '0;
                n_pos         = '0;
                n_depth       = '0;
            end
        end

        o_step = step_close(step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_PRE;
            r_hcnt        <= '0;
            r_tag_group   <= '0;
            r_tag_element <= '0;
            r_vr          <= '0;
            r_len         <= '0;
            r_rem         <= '0;
            r_pos         <= '0;
            r_depth       <= '0;
        end else begin
            r_phase       <= n_phase;
            r_hcnt        <= n_hcnt;
            r_tag_group   <= n_tag_group;
            r_tag_element <= n_tag_element;
            r_vr          <= n_vr;
            r_len         <= n_len;
            r_rem         <= n_rem;
            r_pos         <= n_pos;
            r_depth       <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_nest[r_depth[IDX_W-1:0]] <= push_kind;
        end
    end

    assign o_status.phase_pre = (r_phase == PH_PRE);
    assign o_status.top_level = in_top;

endmodule

@@ rtl/core/dewk_result_queue.sv @@
module dewk_result_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dewk_pkg::t_step                 i_step,
    input  logic                            i_pop,
    output dewk_pkg::t_result               o_head,
    output logic                            o_valid,
    output logic [dewk_pkg::RESQ_LVL_W-1:0] o_level
);
    import dewk_pkg::*;

    t_result                r_entry [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0]  r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr, wr_ptr_p1;
    logic [RESQ_LVL_W-1:0]  r_level, n_level, push_cnt;
    logic                   pop;

    assign o_valid   = (r_level != '0);
    assign pop       = i_pop && o_valid;
    assign push_cnt  = RESQ_LVL_W'(i_step.v0) + RESQ_LVL_W'(i_step.v1);
    assign wr_ptr_p1 = r_wr_ptr + RESQ_PTR_W'(1);
    assign n_wr_ptr  = r_wr_ptr + RESQ_PTR_W'(push_cnt);
    assign n_rd_ptr  = r_rd_ptr + RESQ_PTR_W'(pop);
    assign n_level   = r_level + push_cnt - RESQ_LVL_W'(pop);
    assign o_head    = r_entry[r_rd_ptr];
    assign o_level   = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.v0) begin
            r_entry[r_wr_ptr] <= i_step.r0;
        end
        if (i_step.v1) begin
            r_entry[wr_ptr_p1] <= i_step.r1;
        end
    end

endmodule

@@ rtl/core/dicom_element_stream_walker.sv @@
// An accepted word is registered, then walked once the result queue has room for its
// results, and its first result is offered on the output from the queue's head.
// Throughput: one word per cycle unless o_stall; the single output port drains one
// result per cycle while i_stall is low; a word's second result waits in the queue.
// Reset (synchronous, active low) returns the walker to the preamble and empties the
// input register and the result queue; a word with stream end re-arms the walker too.
module dicom_element_stream_walker #(
    parameter int MAX_DEPTH = dewk_pkg::MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_group_number,
    output logic [15:0] o_element_number,
    output logic [7:0]  o_value_byte,
    output logic [31:0] o_value_index,
    output logic        o_value_end,
    output logic [2:0]  o_error_code,
    output logic        o_run_last
);
    import dewk_pkg::*;

    logic                  r_in_valid, n_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_end;
    logic                  accept, proc;
    t_step                 step;
    t_walk_status          status;
    t_result               head;
    logic [RESQ_LVL_W-1:0] level;

    // A held word is walked only when the queue can take both of its possible results.
    assign proc       = r_in_valid && (level <= RESQ_LVL_W'(RESQ_DEPTH - 2));
    assign o_stall    = r_in_valid && !proc;
    assign accept     = i_valid && !o_stall;
    assign n_in_valid = accept || (r_in_valid && !proc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    dewk_walker #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (proc),
        .i_data_byte  (r_in_byte),
        .i_stream_end (r_in_end),
        .o_step       (step),
        .o_status     (status)
    );

    dewk_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pop   (!i_stall),
        .o_head  (head),
        .o_valid (o_valid),
        .o_level (level)
    );

    assign o_kind           = head.kind;
    assign o_group_number   = head.group_number;
    assign o_element_number = head.element_number;
    assign o_value_byte     = head.value_byte;
    assign o_value_index    = head.value_index;
    assign o_value_end      = head.value_end;
    assign o_error_code     = head.error_code;
    assign o_run_last       = head.run_last;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= RESQ_LVL_W'(RESQ_DEPTH))
        else $error("result queue over capacity");

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_end) |=> (status.phase_pre && status.top_level))
        else $error("walker not re-armed after stream end");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> $stable(status))
        else $error("walker state moved without a word");

    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.v1 |-> (step.v0 && !step.r0.run_last && step.r1.run_last))
        else $error("run_last misplaced on a two-result word");

endmodule
